// ===== hdl/spvm_pkg.sv =====
package spvm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int SUM_W    = 40;
	localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;

	// 1.0 in unsigned q1.15
	localparam logic [GAIN_W-1:0] ONE_Q15 = 16'h8000;

	// a run length well within the 256 full-scale products that the 40 bit sums hold without wrapping
	localparam int MAX_SOURCES = 16;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_left;
		logic signed [SAMPLE_W-1:0] sample_right;
		logic                       stereo_src;
		logic        [GAIN_W-1:0]   volume;
		logic signed [SAMPLE_W-1:0] pan;
		logic                       source_active;
		logic                       last_source;
	} src_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mix_left;
		logic signed [SAMPLE_W-1:0] mix_right;
	} mix_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic gain;
		logic accum;
		logic emit;
	} spvm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_s1;
		logic any_active;
		logic out_busy;
	} spvm_status_t;

endpackage

// ===== hdl/spvm_ctrl.sv =====
module spvm_ctrl
	import spvm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         src_valid,
	output logic         src_stall,
	input  spvm_status_t status,
	output spvm_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GAIN = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;
	logic       emit_go;

	// a new beat may enter while idle or while a non-final item accumulates
	assign src_stall = !((state_q == ST_IDLE) || ((state_q == ST_ACC) && !status.last_s1));
	assign accept    = src_valid && !src_stall;

	// emit waits only when there is a mix to hand over and the output is held
	assign emit_go = (state_q == ST_EMIT) && !(status.any_active && status.out_busy);

	assign cmd.load  = accept;
	assign cmd.gain  = (state_q == ST_GAIN);
	assign cmd.accum = (state_q == ST_ACC);
	assign cmd.emit  = emit_go;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_GAIN;
			end
			ST_GAIN: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				if (status.last_s1) state_d = ST_EMIT;
				else if (accept)    state_d = ST_GAIN;
				else                state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (emit_go) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

// ===== hdl/spvm_datapath.sv =====
module spvm_datapath
	import spvm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  src_item_t    src_data,
	input  spvm_cmd_t    cmd,
	output spvm_status_t status,
	output logic         mix_valid,
	input  logic         mix_stall,
	output mix_item_t    mix_data
);

	src_item_t                 item_q;
	logic        [GAIN_W-1:0]  gain_l_s1;
	logic        [GAIN_W-1:0]  gain_r_s1;
	logic signed [SAMPLE_W-1:0] samp_l_s1;
	logic signed [SAMPLE_W-1:0] samp_r_s1;
	logic                      active_s1;
	logic                      last_s1;
	logic        [SUM_W-1:0]   left_sum_q;
	logic        [SUM_W-1:0]   right_sum_q;
	logic                      any_active_q;
	logic                      mix_valid_q;
	mix_item_t                 mix_q;

	logic        [GAIN_W-1:0]  fac_l;
	logic        [GAIN_W-1:0]  fac_r;
	logic        [2*GAIN_W-1:0] vol_fl;
	logic        [2*GAIN_W-1:0] vol_fr;
	logic signed [PROD_W-1:0]  prod_l;
	logic signed [PROD_W-1:0]  prod_r;

	// round half up, arithmetic shift back to q0, saturate to 16 bits
	function automatic logic [SAMPLE_W-1:0] scale_out(input logic [SUM_W-1:0] s);
		logic signed [SUM_W:0]    rnd;
		logic signed [SUM_W-15:0] shf;
		logic [SAMPLE_W-1:0]      res;
		rnd = $signed({s[SUM_W-1], s}) + $signed((SUM_W+1)'(16384));
		shf = rnd[SUM_W:15];
		if (shf > $signed((SUM_W-14)'(32767)))       res = 16'h7fff;
		else if (shf < -$signed((SUM_W-14)'(32768))) res = 16'h8000;
		else                                          res = shf[SAMPLE_W-1:0];
		return res;
	endfunction

	// pan factors: positive pan trims the left, negative pan trims the right
	always_comb begin
		fac_l = ONE_Q15;
		fac_r = ONE_Q15;
		if (!item_q.pan[SAMPLE_W-1] && (item_q.pan != '0)) fac_l = ONE_Q15 - item_q.pan;
		else if (item_q.pan[SAMPLE_W-1])                   fac_r = ONE_Q15 + item_q.pan;
	end

	assign vol_fl = {{GAIN_W{1'b0}}, item_q.volume} * {{GAIN_W{1'b0}}, fac_l};
	assign vol_fr = {{GAIN_W{1'b0}}, item_q.volume} * {{GAIN_W{1'b0}}, fac_r};

	// sample times gain, gain taken as non-negative
	assign prod_l = PROD_W'(samp_l_s1) * PROD_W'($signed({1'b0, gain_l_s1}));
	assign prod_r = PROD_W'(samp_r_s1) * PROD_W'($signed({1'b0, gain_r_s1}));

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= src_data;
	end

	// gain stage, mono source routed to both sides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_s1 <= 1'b0;
			last_s1   <= 1'b0;
		end else if (cmd.gain) begin
			active_s1 <= item_q.source_active;
			last_s1   <= item_q.last_source;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.gain) begin
			gain_l_s1 <= vol_fl[30:15];
			gain_r_s1 <= vol_fr[30:15];
			samp_l_s1 <= item_q.sample_left;
			samp_r_s1 <= item_q.stereo_src ? item_q.sample_right : item_q.sample_left;
		end
	end

	// accumulate, cleared when the run is closed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_sum_q   <= '0;
			right_sum_q  <= '0;
			any_active_q <= 1'b0;
		end else if (cmd.emit) begin
			left_sum_q   <= '0;
			right_sum_q  <= '0;
			any_active_q <= 1'b0;
		end else if (cmd.accum && active_s1) begin
			left_sum_q   <= left_sum_q + SUM_W'(prod_l);
			right_sum_q  <= right_sum_q + SUM_W'(prod_r);
			any_active_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_valid_q <= 1'b0;
		end else if (cmd.emit && any_active_q) begin
			mix_valid_q <= 1'b1;
		end else if (!mix_stall) begin
			mix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && any_active_q) begin
			mix_q.mix_left  <= scale_out(left_sum_q);
			mix_q.mix_right <= scale_out(right_sum_q);
		end
	end

	assign mix_valid = mix_valid_q;
	assign mix_data  = mix_q;

	assign status.last_s1    = last_s1;
	assign status.any_active = any_active_q;
	assign status.out_busy   = mix_valid_q && mix_stall;

endmodule

// ===== hdl/stereo_pan_volume_mixer_top.sv =====
// stereo pan and volume mixer
//
// src channel: one beat per source at the current frame position, carrying
// the sample pair, stereo flag, volume, pan, active flag and a last-source
// mark. mix channel: one beat with the saturated left and right mix for each
// run that held at least one active source; a run with none gives no beat.
// both channels use valid/stall, a beat moves when valid is high and stall low.
//
// each source beat passes a gain step, forming the two gains (volume times pan
// factor multipliers), then an accumulate step, multiplying the samples and
// adding into the 40 bit sums. the final beat then goes to an emit step that
// rounds, saturates and loads the output register. a new source beat can be
// taken while a non-final one accumulates, but not during gain or emit.
//
// reset clears the sums and output valid flag. if the receiver stalls, the mix
// beat holds and the block keeps taking the next run until its last source
// reaches emit, where an active run waits for the output register to empty.
module stereo_pan_volume_mixer_top
	import spvm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  src_item_t src_data,
	output logic      mix_valid,
	input  logic      mix_stall,
	output mix_item_t mix_data
);

	spvm_cmd_t    cmd;
	spvm_status_t status;

	spvm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.status    (status),
		.cmd       (cmd)
	);

	spvm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_data  (src_data),
		.cmd       (cmd),
		.status    (status),
		.mix_valid (mix_valid),
		.mix_stall (mix_stall),
		.mix_data  (mix_data)
	);

	// an accepted beat goes to the gain step next cycle
	a_load_gain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.gain)
		else $error("accepted beat did not reach gain step");

	// the gain step is always followed by accumulation
	a_gain_acc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gain |=> cmd.accum)
		else $error("gain step not followed by accumulation");

	// no beat is taken while gains are formed
	a_gain_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gain |-> src_stall)
		else $error("input accepted during gain step");

	// closing a run with an active source presents a mix beat
	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && status.any_active) |=> mix_valid)
		else $error("mix beat missing after emit");

endmodule

// ===== sim/stereo_pan_volume_mixer_top_tb.sv =====
`timescale 1ns / 100ps

module stereo_pan_volume_mixer_top_tb;
	import spvm_pkg::*;

	localparam int SRC_BEATS  = 2000;
	localparam int WRAP_RUN   = 300;
	localparam int CYCLE_CAP  = 1000000;
	localparam int TAIL_WAIT  = 12;

	typedef struct {
		src_item_t beat;
		bit        drain;
	} pending_src_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	src_item_t src_data = '0;
	logic      mix_valid;
	logic      mix_stall = 1'b0;
	mix_item_t mix_data;

	// beats waiting to be sent and mixes waiting to come back
	pending_src_t src_queue[$];
	mix_item_t    mix_due[$];

	// running mix of the current run
	logic signed [SUM_W-1:0] left_acc = '0;
	logic signed [SUM_W-1:0] right_acc = '0;
	bit                      run_live = 1'b0;

	int        errors = 0;
	int        cycles = 0;
	int        queued = 0;
	bit        src_took = 1'b0;
	int        src_gap = 0;
	int        src_quiet = 0;
	int        stall_left = 0;
	int        mix_quiet = 0;
	mix_item_t mix_want;

	stereo_pan_volume_mixer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.mix_valid (mix_valid),
		.mix_stall (mix_stall),
		.mix_data  (mix_data)
	);

	always #4 clk = ~clk;

	// rounding, floor shift and saturation of a 40 bit sum
	function automatic logic signed [SAMPLE_W-1:0] to_pcm(logic signed [SUM_W-1:0] acc);
		longint v;
		v = acc;
		v = (v + 16384) >>> 15;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	// add one source beat to the run and close the run on its last source
	task automatic mix_source(input src_item_t it);
		longint    pan_v;
		longint    fac_l;
		longint    fac_r;
		longint    gain_l;
		longint    gain_r;
		longint    smp_l;
		longint    smp_r;
		mix_item_t res;
		pan_v = $signed(it.pan);
		fac_l = longint'(ONE_Q15);
		fac_r = longint'(ONE_Q15);
		if (it.source_active) begin
			if (pan_v > 0)
				fac_l = longint'(ONE_Q15) - pan_v;
			else if (pan_v < 0)
				fac_r = longint'(ONE_Q15) + pan_v;
			gain_l = (longint'(it.volume) * fac_l) >>> 15;
			gain_r = (longint'(it.volume) * fac_r) >>> 15;
			smp_l = $signed(it.sample_left);
			smp_r = $signed(it.sample_right);
			if (!it.stereo_src)
				smp_r = smp_l;
			left_acc = left_acc + 40'(smp_l * gain_l);
			right_acc = right_acc + 40'(smp_r * gain_r);
			run_live = 1'b1;
		end
		if (it.last_source) begin
			if (run_live) begin
				res.mix_left = to_pcm(left_acc);
				res.mix_right = to_pcm(right_acc);
				mix_due.push_back(res);
			end
			left_acc = '0;
			right_acc = '0;
			run_live = 1'b0;
		end
	endtask

	function automatic src_item_t src_beat(logic [15:0] sl, logic [15:0] sr, logic st,
		logic [15:0] vol, logic [15:0] pan, logic act, logic last);
		src_item_t b;
		b.sample_left = sl;
		b.sample_right = sr;
		b.stereo_src = st;
		b.volume = vol;
		b.pan = pan;
		b.source_active = act;
		b.last_source = last;
		return b;
	endfunction

	task automatic queue_beat(input src_item_t b, input bit drain);
		pending_src_t p;
		p.beat = b;
		p.drain = drain;
		src_queue.push_back(p);
		queued++;
	endtask

	// 16 bit value with the extremes well represented
	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4: return 16'h0001;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_volume();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return ONE_Q15;
			2: return 16'hFFFF;
			3: return 16'($urandom_range(32769, 65535));
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	// mostly short idles, a few long ones, none during a quiet stretch
	function automatic int pick_gap(int quiet);
		int r;
		if (quiet > 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// one run of random source beats
	task automatic queue_run(input int len, input bit drain, input int silent);
		src_item_t b;
		for (int i = 0; i < len; i++) begin
			b = src_beat(pick16(), pick16(), 1'($urandom), pick_volume(), pick16(),
				(silent == 1) ? 1'b0 : ($urandom_range(0, 6) != 0),
				i == len - 1);
			queue_beat(b, drain && i == 0);
		end
	endtask

	// beat driver
	always @(negedge clk) begin
		src_quiet <= (src_quiet > 0) ? src_quiet - 1 :
			(($urandom_range(0, 59) == 0) ? $urandom_range(30, 120) : 0);
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else if (src_valid && !src_took) begin
			// stalled, hold the beat
		end else if (src_gap > 0) begin
			src_gap <= src_gap - 1;
			src_valid <= 1'b0;
		end else if (src_queue.size() != 0 &&
				!(src_queue[0].drain && mix_due.size() != 0)) begin
			src_data <= src_queue[0].beat;
			src_queue.pop_front();
			src_valid <= 1'b1;
			src_gap <= pick_gap(src_quiet);
		end else begin
			src_valid <= 1'b0;
		end
	end

	// receiver stall
	always @(negedge clk) begin
		mix_quiet <= (mix_quiet > 0) ? mix_quiet - 1 :
			(($urandom_range(0, 59) == 0) ? $urandom_range(30, 120) : 0);
		if (!arst_n) begin
			mix_stall <= 1'b0;
		end else if (stall_left > 0) begin
			mix_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			mix_stall <= 1'b0;
			stall_left <= pick_gap(mix_quiet);
		end
	end

	// predict on accepted source beats, check accepted mix beats
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("stereo_pan_volume_mixer_top_tb: FAIL");
			$finish;
		end else begin
			src_took = arst_n && src_valid && !src_stall;
			if (src_took)
				mix_source(src_data);
			if (arst_n && mix_valid === 1'b1 && !mix_stall) begin
				if (mix_due.size() == 0) begin
					$error("mix beat with nothing expected: left %0d right %0d",
						mix_data.mix_left, mix_data.mix_right);
					errors++;
				end else begin
					mix_want = mix_due.pop_front();
					if (mix_data.mix_left !== mix_want.mix_left) begin
						$error("mix_left expected %0d got %0d",
							mix_want.mix_left, mix_data.mix_left);
						errors++;
					end
					if (mix_data.mix_right !== mix_want.mix_right) begin
						$error("mix_right expected %0d got %0d",
							mix_want.mix_right, mix_data.mix_right);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		bit wrap_done;
		int r;
		int len;
		wrap_done = 1'b0;

		// directed: extremes of gain and pan, one-beat runs
		queue_beat(src_beat(16'h7FFF, 16'h8000, 1'b1, ONE_Q15, 16'h0000, 1'b1, 1'b1), 1'b0);
		queue_beat(src_beat(16'h8000, 16'h3039, 1'b0, 16'hFFFF, 16'h7FFF, 1'b1, 1'b1), 1'b0);
		queue_beat(src_beat(16'h7FFF, 16'h7FFF, 1'b1, 16'hFFFF, 16'h8000, 1'b1, 1'b1), 1'b0);
		queue_beat(src_beat(16'h1234, 16'hEDCB, 1'b1, 16'h0000, 16'h0001, 1'b1, 1'b1), 1'b0);
		// run with no active source gives no mix
		queue_beat(src_beat(16'h7FFF, 16'h7FFF, 1'b1, 16'hFFFF, 16'h0000, 1'b0, 1'b0), 1'b0);
		queue_beat(src_beat(16'h8000, 16'h8000, 1'b0, ONE_Q15, 16'h8000, 1'b0, 1'b0), 1'b0);
		queue_beat(src_beat(16'h4000, 16'hC000, 1'b1, ONE_Q15, 16'h7FFF, 1'b0, 1'b1), 1'b0);
		// inactive last source still closes an active run
		queue_beat(src_beat(16'h5A5A, 16'h0000, 1'b0, 16'h6000, 16'hFFFF, 1'b1, 1'b0), 1'b0);
		queue_beat(src_beat(16'h7FFF, 16'h7FFF, 1'b1, 16'hFFFF, 16'h0001, 1'b0, 1'b1), 1'b0);
		// saturation both ways
		for (int i = 0; i < 4; i++)
			queue_beat(src_beat(16'h7FFF, 16'h8000, 1'b1, 16'hFFFF, 16'h0000, 1'b1,
				i == 3), 1'b0);
		for (int i = 0; i < 2; i++)
			queue_beat(src_beat(16'h8000, 16'h7FFF, 1'b1, 16'hFFFF, 16'h0000, 1'b1,
				i == 1), 1'b0);
		queue_beat(src_beat(16'hC3A5, 16'h3C5A, 1'b1, 16'h2345, 16'h0001, 1'b1, 1'b1), 1'b0);

		// random runs, the first one after a full drain
		queue_run(3, 1'b1, 0);
		while (queued < SRC_BEATS) begin
			if (!wrap_done && queued > SRC_BEATS / 2) begin
				// long run that wraps the sums
				for (int i = 0; i < WRAP_RUN; i++)
					queue_beat(src_beat(16'h8000, 16'h8000, 1'b1, 16'hFFFF, 16'h0000,
						1'b1, i == WRAP_RUN - 1), 1'b0);
				wrap_done = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 60)
				len = $urandom_range(1, 4);
			else if (r < 95)
				len = $urandom_range(5, MAX_SOURCES);
			else
				len = $urandom_range(MAX_SOURCES + 1, 40);
			queue_run(len, $urandom_range(0, 32) == 0, ($urandom_range(0, 19) == 0) ? 1 : 0);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for the queue to empty and every mix to arrive
		while (src_queue.size() != 0 || src_valid || mix_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (errors == 0)
			$display("stereo_pan_volume_mixer_top_tb: PASS");
		else
			$display("stereo_pan_volume_mixer_top_tb: FAIL");
		$finish;
	end

endmodule
